### rtl/mtrc_pkg.sv
// ----------------------------------------------------------------------------
// mtrc_pkg
// Types and codes shared by the millisecond RTC with fractional compare.
// ----------------------------------------------------------------------------
package mtrc_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FIX_NONE     = 2'd0,
    FIX_MARK     = 2'd1,
    FIX_MIDNIGHT = 2'd2
  } fix_t;

  typedef enum logic [1:0] {
    CFG_TRIM_INTERVAL   = 2'd0,
    CFG_TRIM_SUBTRACT   = 2'd1,
    CFG_REPORT_HOUR     = 2'd2,
    CFG_REPORT_INTERVAL = 2'd3
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [10:0] MS_PER_SEC  = 11'd1000;
  localparam logic [10:0] MS_LAST     = 11'd999;
  localparam logic [6:0]  SEC_PER_MIN = 7'd60;
  localparam logic [6:0]  MIN_PER_HR  = 7'd60;
  localparam logic [5:0]  HR_PER_DAY  = 6'd24;
  localparam logic [15:0] STEP_LONG   = 16'd33;
  localparam logic [15:0] STEP_SHORT  = 16'd32;
  localparam logic [2:0]  PHASE_FOUR  = 3'd4;
  localparam logic [4:0]  PHASE_14    = 5'd14;
  localparam logic [15:0] COMPARE_RST = 16'd33;

  typedef struct packed {
    logic [15:0] trim_interval;
    logic        trim_subtract;
    logic [4:0]  report_hour;
    logic [7:0]  report_interval_days;
  } cfg_t;

  typedef struct packed {
    op_t         operation;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
    logic [9:0]  load_millisecond;
  } req_t;

  typedef struct packed {
    logic [9:0] ms_count;
    logic       set_pending;
  } clk_sts_t;

  typedef struct packed {
    logic [9:0]  millisecond;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [15:0] day_count;
    logic        second_tick;
    logic        minute_sync;
    fix_t        fix_code;
    logic        status_report;
    logic        rtc_write_request;
  } clk_res_t;

endpackage

### rtl/mtrc_step.sv
// ----------------------------------------------------------------------------
// mtrc_step
// Compare step sequencer: 33/32 phase pattern, second closing and trim.
// ----------------------------------------------------------------------------
module mtrc_step #(
  parameter int unsigned TICKS_PER_SECOND = 32768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  mtrc_pkg::req_t     req,
  input  mtrc_pkg::cfg_t     cfg,
  input  mtrc_pkg::clk_sts_t sts,
  output logic [15:0]        step,
  output logic [15:0]        compare_value
);
  import mtrc_pkg::*;

  localparam logic [16:0] TPS = 17'(TICKS_PER_SECOND);

  logic [1:0]  phase_four_r, phase_four_nxt;
  logic [3:0]  phase_14_r, phase_14_nxt;
  logic [16:0] tis_r, tis_nxt;
  logic [15:0] compare_r, compare_nxt;
  logic [15:0] trim_count_r, trim_count_nxt;

  logic [10:0] ms1;
  logic        roll;
  logic [1:0]  pf_base;
  logic [3:0]  p14_base;
  logic [16:0] tis_base;
  logic [2:0]  pf1;
  logic [4:0]  p14_1;
  logic [15:0] base_step;
  logic [16:0] tis_sum;
  logic [15:0] tick_step;
  logic [15:0] tc_inc;

  always_comb begin
    ms1      = {1'b0, sts.ms_count} + 11'd1;
    roll     = (ms1 >= MS_PER_SEC);
    pf_base  = roll ? 2'd0 : phase_four_r;
    p14_base = roll ? 4'd0 : phase_14_r;
    tis_base = roll ? 17'd0 : tis_r;
    pf1      = {1'b0, pf_base} + 3'd1;
    p14_1    = {1'b0, p14_base} + 5'd1;

    phase_four_nxt = pf1[1:0];
    phase_14_nxt   = p14_base;
    base_step      = STEP_LONG;
    if (pf1 >= PHASE_FOUR) begin
      phase_four_nxt = 2'd0;
      if (p14_1 >= PHASE_14) begin
        phase_14_nxt = 4'd0;
      end else begin
        phase_14_nxt = p14_1[3:0];
        base_step    = STEP_SHORT;
      end
    end

    tis_sum   = tis_base + 17'(base_step);
    tis_nxt   = tis_sum;
    tick_step = base_step;
    if (ms1 == MS_LAST) begin
      if (sts.set_pending) begin
        tick_step = STEP_LONG;
      end else if (({1'b0, tis_sum} + 18'(base_step)) > {1'b0, TPS}) begin
        tick_step = base_step + 16'd1;
        tis_nxt   = tis_sum + 17'd1;
      end else begin
        tick_step = base_step + TPS[15:0] - tis_sum[15:0];
        tis_nxt   = TPS;
      end
    end

    tc_inc         = trim_count_r + 16'd1;
    trim_count_nxt = trim_count_r;
    if (cfg.trim_interval != 16'd0) begin
      trim_count_nxt = tc_inc;
      if (tc_inc >= cfg.trim_interval) begin
        trim_count_nxt = 16'd0;
        tick_step      = cfg.trim_subtract ? tick_step - 16'd1 : tick_step + 16'd1;
      end
    end

    if (req.operation == OP_LOAD) begin
      step           = 16'd0;
      phase_four_nxt = phase_four_r;
      phase_14_nxt   = phase_14_r;
      tis_nxt        = tis_r;
      trim_count_nxt = trim_count_r;
    end else begin
      step = tick_step;
    end
    compare_nxt   = compare_r + step;
    compare_value = compare_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_four_r <= '0;
      phase_14_r   <= '0;
      tis_r        <= '0;
      compare_r    <= COMPARE_RST;
      trim_count_r <= '0;
    end else if (advance) begin
      phase_four_r <= phase_four_nxt;
      phase_14_r   <= phase_14_nxt;
      tis_r        <= tis_nxt;
      compare_r    <= compare_nxt;
      trim_count_r <= trim_count_nxt;
    end
  end

endmodule

### rtl/mtrc_clock.sv
// ----------------------------------------------------------------------------
// mtrc_clock
// Time-of-day counters, marks, daily status countdown and set tracking.
// ----------------------------------------------------------------------------
module mtrc_clock (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  mtrc_pkg::req_t     req,
  input  mtrc_pkg::cfg_t     cfg,
  output mtrc_pkg::clk_sts_t sts,
  output mtrc_pkg::clk_res_t res
);
  import mtrc_pkg::*;

  logic [9:0]  ms_r, ms_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [15:0] day_r, day_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  days_left_r, days_left_nxt;

  logic [10:0] ms1;
  logic [6:0]  sec1;
  logic [6:0]  min1;
  logic [5:0]  hour1;
  logic [7:0]  dl_dec;

  always_comb begin
    ms1   = {1'b0, ms_r} + 11'd1;
    sec1  = {1'b0, sec_r} + 7'd1;
    min1  = {1'b0, min_r} + 7'd1;
    hour1 = {1'b0, hour_r} + 6'd1;
    dl_dec = days_left_r - 8'd1;

    ms_nxt        = ms_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    day_nxt       = day_r;
    pend_nxt      = pend_r;
    days_left_nxt = days_left_r;
    res.second_tick       = 1'b0;
    res.minute_sync       = 1'b0;
    res.fix_code          = FIX_NONE;
    res.status_report     = 1'b0;
    res.rtc_write_request = 1'b0;

    if (req.operation == OP_LOAD) begin
      hour_nxt = req.load_hour;
      min_nxt  = req.load_minute;
      sec_nxt  = req.load_second;
      ms_nxt   = req.load_millisecond;
      pend_nxt = 1'b1;
    end else if (ms1 >= MS_PER_SEC) begin
      ms_nxt          = 10'd0;
      res.second_tick = 1'b1;
      sec_nxt         = sec1[5:0];
      if (sec1 >= SEC_PER_MIN) begin
        sec_nxt         = 6'd0;
        min_nxt         = min1[5:0];
        res.minute_sync = (min1[1:0] == 2'd0);
        if (min1 == 7'd15 || min1 == 7'd30 || min1 == 7'd45) begin
          res.fix_code = FIX_MARK;
        end
        if (min1 >= MIN_PER_HR) begin
          min_nxt  = 6'd0;
          hour_nxt = hour1[4:0];
          if (hour1 >= HR_PER_DAY) begin
            hour_nxt = 5'd0;
            day_nxt  = day_r + 16'd1;
          end
          res.fix_code = (hour_nxt != 5'd0) ? FIX_MARK : FIX_MIDNIGHT;
          if (hour_nxt == cfg.report_hour && days_left_r != 8'd0) begin
            days_left_nxt = dl_dec;
            if (dl_dec == 8'd0) begin
              res.status_report = 1'b1;
              days_left_nxt     = cfg.report_interval_days;
            end
          end
        end
      end
      if (pend_r) begin
        pend_nxt              = 1'b0;
        res.rtc_write_request = 1'b1;
      end
    end else begin
      ms_nxt = ms1[9:0];
    end

    res.millisecond = ms_nxt;
    res.second      = sec_nxt;
    res.minute      = min_nxt;
    res.hour        = hour_nxt;
    res.day_count   = day_nxt;
    sts.ms_count    = ms_r;
    sts.set_pending = pend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r        <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      day_r       <= '0;
      pend_r      <= 1'b0;
      days_left_r <= 8'd1;
    end else if (advance) begin
      ms_r        <= ms_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      pend_r      <= pend_nxt;
      days_left_r <= days_left_nxt;
    end
  end

endmodule

### rtl/ms_tick_rtc_fractional_compare_top.sv
// ----------------------------------------------------------------------------
// ms_tick_rtc_fractional_compare_top
// Millisecond RTC: advances the time of day per tick and issues the next
// timer compare step, with crystal trim, quarter-hour marks and a daily report.
// ----------------------------------------------------------------------------
// Each request is captured in an input register, processed by combinational
// logic that updates the clock and compare state as it advances, and presented
// from a result register; the input register and the result register lie
// between the request handshake and the result handshake. One request per cycle
// is sustained while the result side is not stalled: the input register refills
// as the result register is taken, and all state for a request is updated in
// that single step. Configuration writes take effect on the next cycle.
module ms_tick_rtc_fractional_compare_top #(
  parameter int unsigned TICKS_PER_SECOND = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [mtrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [4:0]  in_load_hour,
  input  logic [5:0]  in_load_minute,
  input  logic [5:0]  in_load_second,
  input  logic [9:0]  in_load_millisecond,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_compare_step,
  output logic [15:0] out_compare_value,
  output logic [9:0]  out_millisecond,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [15:0] out_day_count,
  output logic        out_second_tick,
  output logic        out_minute_sync,
  output logic [1:0]  out_fix_code,
  output logic        out_status_report,
  output logic        out_rtc_write_request
);
  import mtrc_pkg::*;

  cfg_t       cfg_r;
  req_t       req_r;
  logic       in_valid_r;
  logic       out_valid_r;
  logic       advance;
  clk_sts_t   sts;
  clk_res_t   res;
  clk_res_t   res_r;
  logic [15:0] step;
  logic [15:0] compare_value;
  logic [15:0] step_r;
  logic [15:0] compare_r;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trim_interval        <= '0;
      cfg_r.trim_subtract        <= 1'b0;
      cfg_r.report_hour          <= '0;
      cfg_r.report_interval_days <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIM_INTERVAL:   cfg_r.trim_interval        <= cfg_wdata;
        CFG_TRIM_SUBTRACT:   cfg_r.trim_subtract        <= cfg_wdata[0];
        CFG_REPORT_HOUR:     cfg_r.report_hour          <= cfg_wdata[4:0];
        CFG_REPORT_INTERVAL: cfg_r.report_interval_days <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.operation        <= op_t'(in_operation);
      req_r.load_hour        <= in_load_hour;
      req_r.load_minute      <= in_load_minute;
      req_r.load_second      <= in_load_second;
      req_r.load_millisecond <= in_load_millisecond;
    end
  end

  mtrc_clock u_clock (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_r),
    .cfg     (cfg_r),
    .sts     (sts),
    .res     (res)
  );

  mtrc_step #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .req           (req_r),
    .cfg           (cfg_r),
    .sts           (sts),
    .step          (step),
    .compare_value (compare_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r     <= res;
      step_r    <= step;
      compare_r <= compare_value;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_compare_step      = step_r;
  assign out_compare_value     = compare_r;
  assign out_millisecond       = res_r.millisecond;
  assign out_second            = res_r.second;
  assign out_minute            = res_r.minute;
  assign out_hour              = res_r.hour;
  assign out_day_count         = res_r.day_count;
  assign out_second_tick       = res_r.second_tick;
  assign out_minute_sync       = res_r.minute_sync;
  assign out_fix_code          = res_r.fix_code;
  assign out_status_report     = res_r.status_report;
  assign out_rtc_write_request = res_r.rtc_write_request;

  a_load_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && req_r.operation == OP_LOAD |=> out_valid && out_compare_step == 16'd0)
    else $error("load request produced a nonzero compare step");

  a_wreq_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rtc_write_request |-> out_second_tick)
    else $error("RTC write request outside a second rollover");

  a_sync_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_minute_sync || out_status_report) |-> out_second_tick)
    else $error("minute flag without a second rollover");

  a_report_on_hour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status_report |-> out_fix_code != FIX_NONE && out_minute == 6'd0)
    else $error("status report outside an hour mark");

  a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(req_r))
    else $error("pending request lost while stalled");

endmodule

### verif/ms_tick_rtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ms_tick_rtc_checker
// Watches the register port and the request and result channels of the millisecond
// RTC. Keeps its own copy of the clock, phase, compare, trim and countdown
// state, predicts the result of every accepted request, and compares each
// delivered result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ms_tick_rtc_checker #(
  parameter int unsigned TICKS_PER_SECOND = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [4:0]  in_load_hour,
  input  logic [5:0]  in_load_minute,
  input  logic [5:0]  in_load_second,
  input  logic [9:0]  in_load_millisecond,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_compare_step,
  input  logic [15:0] out_compare_value,
  input  logic [9:0]  out_millisecond,
  input  logic [5:0]  out_second,
  input  logic [5:0]  out_minute,
  input  logic [4:0]  out_hour,
  input  logic [15:0] out_day_count,
  input  logic        out_second_tick,
  input  logic        out_minute_sync,
  input  logic [1:0]  out_fix_code,
  input  logic        out_status_report,
  input  logic        out_rtc_write_request,
  output int unsigned fail_count,
  output int unsigned results_outstanding,
  output int unsigned rollovers_seen,
  output int unsigned reports_seen
);
  import mtrc_pkg::*;

  typedef struct packed {
    logic [15:0] compare_step;
    logic [15:0] compare_value;
    logic [9:0]  millisecond;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [15:0] day_count;
    logic        second_tick;
    logic        minute_sync;
    fix_t        fix_code;
    logic        status_report;
    logic        rtc_write_request;
  } rtc_result_t;

  logic [15:0] trim_interval_q;
  logic        trim_subtract_q;
  logic [4:0]  report_hour_q;
  logic [7:0]  report_days_q;

  logic [9:0]  ms_q;
  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hour_q;
  logic [15:0] day_q;
  logic [1:0]  phase4_q;
  logic [3:0]  phase14_q;
  logic [16:0] sec_ticks_q;
  logic [15:0] compare_q;
  logic [15:0] trim_count_q;
  logic        set_pending_q;
  logic [7:0]  days_left_q;

  rtc_result_t expected_results[$];

  task automatic advance_rtc(input op_t op, input logic [4:0] ld_hour,
                             input logic [5:0] ld_min, input logic [5:0] ld_sec,
                             input logic [9:0] ld_ms, output rtc_result_t res);
    int unsigned step, ms, p4, p14, sum, mins, hrs;
    logic        sec_flag, sync_flag, report, wreq;
    fix_t        fix;
    step      = 0;
    sec_flag  = 1'b0;
    sync_flag = 1'b0;
    report    = 1'b0;
    wreq      = 1'b0;
    fix       = FIX_NONE;
    if (op == OP_LOAD) begin
      hour_q        = ld_hour;
      min_q         = ld_min;
      sec_q         = ld_sec;
      ms_q          = ld_ms;
      set_pending_q = 1'b1;
    end else begin
      ms = ms_q + 1;
      if (ms >= MS_PER_SEC) begin
        phase4_q    = '0;
        phase14_q   = '0;
        sec_ticks_q = '0;
      end
      p4 = phase4_q + 1;
      if (p4 >= PHASE_FOUR) begin
        p14 = phase14_q + 1;
        if (p14 >= PHASE_14) begin
          step = STEP_LONG;
          p14  = 0;
        end else begin
          step = STEP_SHORT;
        end
        phase14_q = p14[3:0];
        p4 = 0;
      end else begin
        step = STEP_LONG;
      end
      phase4_q = p4[1:0];
      sum = sec_ticks_q + step;
      sec_ticks_q = sum[16:0];

      if (ms == MS_LAST) begin
        if (set_pending_q) begin
          step = STEP_LONG;
        end else if (sec_ticks_q + step > TICKS_PER_SECOND) begin
          step = step + 1;
          sum = sec_ticks_q + 1;
          sec_ticks_q = sum[16:0];
        end else begin
          step = step + TICKS_PER_SECOND - sec_ticks_q;
          sum = TICKS_PER_SECOND;
          sec_ticks_q = sum[16:0];
        end
      end

      if (trim_interval_q != 0) begin
        trim_count_q = trim_count_q + 16'd1;
        if (trim_count_q >= trim_interval_q) begin
          trim_count_q = '0;
          if (trim_subtract_q) step = step - 1;
          else step = step + 1;
        end
      end
      compare_q = compare_q + step[15:0];

      if (ms >= MS_PER_SEC) begin
        ms = 0;
        sec_flag = 1'b1;
        if (sec_q + 1 >= SEC_PER_MIN) begin
          sec_q = '0;
          mins = min_q + 1;
          if (mins[1:0] == 2'b00) sync_flag = 1'b1;
          if (mins % 15 == 0 && mins < MIN_PER_HR) fix = FIX_MARK;
          if (mins >= MIN_PER_HR) begin
            mins = 0;
            hrs = hour_q + 1;
            if (hrs >= HR_PER_DAY) begin
              hrs = 0;
              day_q = day_q + 16'd1;
            end
            fix = (hrs > 0) ? FIX_MARK : FIX_MIDNIGHT;
            if (hrs == report_hour_q && days_left_q != 0) begin
              days_left_q = days_left_q - 8'd1;
              if (days_left_q == 0) begin
                report = 1'b1;
                days_left_q = report_days_q;
              end
            end
            hour_q = hrs[4:0];
          end
          min_q = mins[5:0];
        end else begin
          sec_q = sec_q + 6'd1;
        end
        if (set_pending_q) begin
          set_pending_q = 1'b0;
          wreq = 1'b1;
        end
      end
      ms_q = ms[9:0];
    end

    res.compare_step      = step[15:0];
    res.compare_value     = compare_q;
    res.millisecond       = ms_q;
    res.second            = sec_q;
    res.minute            = min_q;
    res.hour              = hour_q;
    res.day_count         = day_q;
    res.second_tick       = sec_flag;
    res.minute_sync       = sync_flag;
    res.fix_code          = fix;
    res.status_report     = report;
    res.rtc_write_request = wreq;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rtc_result_t predicted, oldest;
    if (!rst_n) begin
      trim_interval_q = '0;
      trim_subtract_q = 1'b0;
      report_hour_q   = '0;
      report_days_q   = 8'd1;
      ms_q            = '0;
      sec_q           = '0;
      min_q           = '0;
      hour_q          = '0;
      day_q           = '0;
      phase4_q        = '0;
      phase14_q       = '0;
      sec_ticks_q     = '0;
      compare_q       = COMPARE_RST;
      trim_count_q    = '0;
      set_pending_q   = 1'b0;
      days_left_q     = 8'd1;
      fail_count      = 0;
      rollovers_seen  = 0;
      reports_seen    = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TRIM_INTERVAL:   trim_interval_q = cfg_wdata;
          CFG_TRIM_SUBTRACT:   trim_subtract_q = cfg_wdata[0];
          CFG_REPORT_HOUR:     report_hour_q   = cfg_wdata[4:0];
          CFG_REPORT_INTERVAL: report_days_q   = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_rtc(op_t'(in_operation), in_load_hour, in_load_minute, in_load_second,
                    in_load_millisecond, predicted);
        expected_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (out_second_tick) rollovers_seen++;
        if (out_status_report) reports_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result delivered with no request outstanding", $time);
        end else begin
          oldest = expected_results.pop_front();
          check_field("compare_step", oldest.compare_step, out_compare_step);
          check_field("compare_value", oldest.compare_value, out_compare_value);
          check_field("millisecond", oldest.millisecond, out_millisecond);
          check_field("second", oldest.second, out_second);
          check_field("minute", oldest.minute, out_minute);
          check_field("hour", oldest.hour, out_hour);
          check_field("day_count", oldest.day_count, out_day_count);
          check_field("second_tick", oldest.second_tick, out_second_tick);
          check_field("minute_sync", oldest.minute_sync, out_minute_sync);
          check_field("fix_code", oldest.fix_code, out_fix_code);
          check_field("status_report", oldest.status_report, out_status_report);
          check_field("rtc_write_request", oldest.rtc_write_request,
                      out_rtc_write_request);
        end
      end
    end
    results_outstanding = expected_results.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the millisecond RTC with directed time loads and ticks, one full
// second of plain ticks, then randomized load-and-tick sequences aimed at
// second, minute, hour and day boundaries under several trim and report
// settings, with random idle gaps and result stalls. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import mtrc_pkg::*;

  localparam int unsigned TICKS_PER_SECOND = 32768;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic [4:0]  in_load_hour = '0;
  logic [5:0]  in_load_minute = '0;
  logic [5:0]  in_load_second = '0;
  logic [9:0]  in_load_millisecond = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [15:0] out_compare_step;
  logic [15:0] out_compare_value;
  logic [9:0]  out_millisecond;
  logic [5:0]  out_second;
  logic [5:0]  out_minute;
  logic [4:0]  out_hour;
  logic [15:0] out_day_count;
  logic        out_second_tick;
  logic        out_minute_sync;
  logic [1:0]  out_fix_code;
  logic        out_status_report;
  logic        out_rtc_write_request;

  int unsigned fail_count;
  int unsigned results_outstanding;
  int unsigned rollovers_seen;
  int unsigned reports_seen;

  int unsigned sent_count = 0;
  int unsigned received_count = 0;
  int unsigned load_count = 0;
  int unsigned setting_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic [4:0]  report_hour_now = '0;

  always #4 clk = ~clk;

  ms_tick_rtc_fractional_compare_top #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_load_hour(in_load_hour),
    .in_load_minute(in_load_minute),
    .in_load_second(in_load_second),
    .in_load_millisecond(in_load_millisecond),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_compare_step(out_compare_step),
    .out_compare_value(out_compare_value),
    .out_millisecond(out_millisecond),
    .out_second(out_second),
    .out_minute(out_minute),
    .out_hour(out_hour),
    .out_day_count(out_day_count),
    .out_second_tick(out_second_tick),
    .out_minute_sync(out_minute_sync),
    .out_fix_code(out_fix_code),
    .out_status_report(out_status_report),
    .out_rtc_write_request(out_rtc_write_request)
  );

  ms_tick_rtc_checker #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_load_hour(in_load_hour),
    .in_load_minute(in_load_minute),
    .in_load_second(in_load_second),
    .in_load_millisecond(in_load_millisecond),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_compare_step(out_compare_step),
    .out_compare_value(out_compare_value),
    .out_millisecond(out_millisecond),
    .out_second(out_second),
    .out_minute(out_minute),
    .out_hour(out_hour),
    .out_day_count(out_day_count),
    .out_second_tick(out_second_tick),
    .out_minute_sync(out_minute_sync),
    .out_fix_code(out_fix_code),
    .out_status_report(out_status_report),
    .out_rtc_write_request(out_rtc_write_request),
    .fail_count(fail_count),
    .results_outstanding(results_outstanding),
    .rollovers_seen(rollovers_seen),
    .reports_seen(reports_seen)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) received_count++;
  end

  // stall the result side in random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_request(input op_t op, input logic [4:0] hr, input logic [5:0] mn,
                              input logic [5:0] sc, input logic [9:0] ms);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_load_hour        <= hr;
    in_load_minute      <= mn;
    in_load_second      <= sc;
    in_load_millisecond <= ms;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (op == OP_LOAD) load_count++;
  endtask

  task automatic tick_request();
    push_request(OP_TICK, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), 10'($urandom_range(0, 1023)));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (received_count == sent_count);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] trim_int, input logic trim_sub,
                           input logic [4:0] rep_hour, input logic [7:0] rep_days);
    drain();
    write_reg(CFG_TRIM_INTERVAL, trim_int);
    write_reg(CFG_TRIM_SUBTRACT, 16'(trim_sub));
    write_reg(CFG_REPORT_HOUR, 16'(rep_hour));
    write_reg(CFG_REPORT_INTERVAL, 16'(rep_days));
    report_hour_now = rep_hour;
    setting_count++;
  endtask

  // mostly loads just short of a boundary followed by a few ticks, some noise
  task automatic run_sequences(input int unsigned n);
    int unsigned done_items, k;
    logic [4:0]  hr;
    logic [5:0]  mn, sc;
    logic [9:0]  ms;
    done_items = 0;
    while (done_items < n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_request(op_t'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                     6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                     10'($urandom_range(0, 1023)));
        done_items++;
      end else begin
        if ($urandom_range(0, 1) == 1) hr = 5'((report_hour_now + 23) % 24);
        else hr = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 3))
          0, 1: mn = 6'd59;
          2: mn = 6'($urandom_range(0, 3) * 15 + 14);
          default: mn = 6'($urandom_range(0, 63));
        endcase
        sc = ($urandom_range(0, 9) < 7) ? 6'd59 : 6'($urandom_range(0, 63));
        ms = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(995, 1023))
                                        : 10'($urandom_range(0, 1023));
        push_request(OP_LOAD, hr, mn, sc, ms);
        k = $urandom_range(1, 8);
        repeat (k) tick_request();
        done_items += k + 1;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    repeat (4) tick_request();
    push_request(OP_LOAD, 5'd31, 6'd63, 6'd63, 10'd1023);
    tick_request();
    push_request(OP_LOAD, 5'd23, 6'd59, 6'd59, 10'd998);
    repeat (2) tick_request();
    push_request(OP_LOAD, 5'd0, 6'd14, 6'd59, 10'd999);
    tick_request();
    push_request(OP_LOAD, 5'd5, 6'd59, 6'd59, 10'd999);
    tick_request();
    push_request(OP_LOAD, 5'd0, 6'd3, 6'd59, 10'd999);
    tick_request();
    push_request(OP_LOAD, 5'd0, 6'd0, 6'd0, 10'd0);
    tick_request();
    configure(16'd1, 1'b1, 5'd23, 8'd255);
    repeat (2) tick_request();
    configure(16'd2, 1'b0, 5'd5, 8'd2);
    repeat (3) begin
      push_request(OP_LOAD, 5'd4, 6'd59, 6'd59, 10'd999);
      tick_request();
    end

    // one whole second of plain ticks after a rollover clears the pending set
    configure(16'($urandom_range(1, 60)), 1'($urandom_range(0, 1)),
              5'($urandom_range(0, 23)), 8'($urandom_range(1, 3)));
    gap_pct   = 5;
    stall_pct = 5;
    push_request(OP_LOAD, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                 6'($urandom_range(0, 59)), 10'd999);
    repeat (1001) tick_request();

    configure(16'd0, 1'b0, 5'($urandom_range(0, 23)), 8'd1);
    gap_pct   = 30;
    stall_pct = 30;
    run_sequences(20);

    configure(16'd65535, 1'b1, 5'd23, 8'($urandom_range(1, 3)));
    gap_pct   = 10;
    stall_pct = 10;
    run_sequences(20);

    configure(16'd1, 1'b0, 5'd0, 8'd2);
    gap_pct   = 0;
    stall_pct = 0;
    run_sequences(20);

    configure(16'($urandom_range(2, 50)), 1'($urandom_range(0, 1)),
              5'($urandom_range(0, 23)), 8'd1);
    gap_pct   = 10;
    stall_pct = 40;
    run_sequences(20);

    configure(16'($urandom_range(1, 9)), 1'b1, 5'($urandom_range(0, 23)),
              8'($urandom_range(1, 3)));
    gap_pct   = 25;
    stall_pct = 15;
    run_sequences(20);

    configure(16'($urandom_range(0, 20)), 1'($urandom_range(0, 1)),
              5'($urandom_range(0, 23)), 8'd0);
    gap_pct   = 0;
    stall_pct = 0;
    run_sequences(20);

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d requests (%0d time loads) under %0d register settings.",
             sent_count, load_count, setting_count);
    $display("Results held %0d second rollovers and %0d status reports.",
             rollovers_seen, reports_seen);
    if (fail_count == 0 && results_outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/mtrc_pkg.sv
rtl/mtrc_step.sv
rtl/mtrc_clock.sv
rtl/ms_tick_rtc_fractional_compare_top.sv
verif/ms_tick_rtc_checker.sv
verif/testbench.sv
